// ----- src/ahc_pkg.sv -----
// Shared types and constants for the ACPI host command handler.
// No dependencies; compile before the interfaces and modules.
package ahc_pkg;

	localparam logic [7:0] CMD_READ      = 8'h80;
	localparam logic [7:0] CMD_WRITE     = 8'h81;
	localparam logic [7:0] CMD_BURST_EN  = 8'h82;
	localparam logic [7:0] CMD_BURST_DIS = 8'h83;
	localparam logic [7:0] CMD_QUERY     = 8'h84;
	localparam logic [7:0] BURST_ACK     = 8'h90;

	typedef struct packed {
		logic [2:0] req_type;
		logic [7:0] payload;
	} ahc_req_t;

	typedef struct packed {
		logic       out_valid;
		logic [7:0] out_byte;
		logic       sci_pulse;
		logic       read_req;
		logic       write_req;
		logic [7:0] space_addr;
		logic [7:0] space_wdata;
		logic       burst_flag;
		logic       sci_pending_flag;
		logic       sci_accepted;
	} ahc_rsp_t;

endpackage

// ----- src/ahc_ifs.sv -----
// Valid/ready channel interfaces for requests and results.
// Depends on ahc_pkg for the payload structs.
interface ahc_req_if;
	logic             valid;
	logic             ready;
	ahc_pkg::ahc_req_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

interface ahc_rsp_if;
	logic             valid;
	logic             ready;
	ahc_pkg::ahc_rsp_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

// ----- src/acpi_ec_host_command_handler.sv -----
// Top level of the ACPI host command handler: input register, protocol logic, result register.
// Depends on ahc_pkg and the channel interfaces in ahc_ifs.sv.
//
//  channel | modport | payload   | transaction
//  req     | sink    | ahc_req_t | host command/data, buffer free, raise SCI, read return
//  rsp     | source  | ahc_rsp_t | output byte, SCI pulse, space request, status
//
// Every request yields one result, offered on rsp once it has passed the input register and the
// result register. One request is accepted per cycle while rsp is not stalled; the protocol
// state updates as an item enters the result register, so consecutive items see each other's
// effects.
// A stalled result holds; the input register still takes one more request behind it.
// arst_n clears the protocol mode, queue, burst and pending bits and both valid flags.
module acpi_ec_host_command_handler (
	input  logic         clk,
	input  logic         arst_n,
	ahc_req_if.sink      req,
	ahc_rsp_if.source    rsp
);
	import ahc_pkg::*;

	localparam logic [2:0] REQ_CMD   = 3'd0;
	localparam logic [2:0] REQ_DATA  = 3'd1;
	localparam logic [2:0] REQ_OBF   = 3'd2;
	localparam logic [2:0] REQ_SCI   = 3'd3;
	localparam logic [2:0] REQ_RDRET = 3'd4;

	localparam logic [2:0] MODE_IDLE    = 3'd0;
	localparam logic [2:0] MODE_SEND    = 3'd1;
	localparam logic [2:0] MODE_RD_ADDR = 3'd2;
	localparam logic [2:0] MODE_WR_ADDR = 3'd3;
	localparam logic [2:0] MODE_WR_DATA = 3'd4;
	localparam logic [2:0] MODE_RD_WAIT = 3'd5;

	logic       valid_s1;
	ahc_req_t   item_s1;
	logic       rsp_valid_q;
	ahc_rsp_t   rsp_q;
	logic       adv;

	logic [2:0] mode_q, mode_n;
	logic [7:0] held_q, held_n;
	logic [7:0] queued_q, queued_n;
	logic       burst_q, burst_n;
	logic       pending_q, pending_n;
	ahc_rsp_t   res;

	assign adv       = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || adv;
	assign rsp.valid = rsp_valid_q;
	assign rsp.item  = rsp_q;

	always_comb begin
		mode_n    = mode_q;
		held_n    = held_q;
		queued_n  = queued_q;
		burst_n   = burst_q;
		pending_n = pending_q;
		res       = '0;
		case (item_s1.req_type)
			REQ_CMD: begin
				mode_n = MODE_IDLE;
				case (item_s1.payload)
					CMD_READ: begin
						mode_n        = MODE_RD_ADDR;
						res.sci_pulse = 1'b1;
					end
					CMD_WRITE: begin
						mode_n        = MODE_WR_ADDR;
						res.sci_pulse = 1'b1;
					end
					CMD_BURST_EN: begin
						burst_n = 1'b1;
						mode_n  = MODE_SEND;
						held_n  = BURST_ACK;
					end
					CMD_BURST_DIS: begin
						burst_n       = 1'b0;
						res.sci_pulse = 1'b1;
					end
					CMD_QUERY: begin
						pending_n = 1'b0;
						mode_n    = MODE_SEND;
						held_n    = queued_q;
						queued_n  = '0;
					end
					default: begin
						mode_n = MODE_IDLE;
					end
				endcase
			end
			REQ_DATA: begin
				case (mode_q)
					MODE_RD_ADDR: begin
						mode_n         = MODE_RD_WAIT;
						res.read_req   = 1'b1;
						res.space_addr = item_s1.payload;
					end
					MODE_WR_ADDR: begin
						mode_n        = MODE_WR_DATA;
						held_n        = item_s1.payload;
						res.sci_pulse = 1'b1;
					end
					MODE_WR_DATA: begin
						mode_n          = MODE_IDLE;
						res.write_req   = 1'b1;
						res.space_addr  = held_q;
						res.space_wdata = item_s1.payload;
						res.sci_pulse   = 1'b1;
					end
					default: begin
						mode_n = MODE_IDLE;
					end
				endcase
			end
			REQ_OBF: begin
				if (mode_q == MODE_SEND) begin
					mode_n        = MODE_IDLE;
					res.out_valid = 1'b1;
					res.out_byte  = held_q;
					res.sci_pulse = 1'b1;
				end
			end
			REQ_SCI: begin
				pending_n     = 1'b1;
				res.sci_pulse = 1'b1;
				if (queued_q == '0) begin
					queued_n         = item_s1.payload;
					res.sci_accepted = 1'b1;
				end
			end
			REQ_RDRET: begin
				if (mode_q == MODE_RD_WAIT) begin
					mode_n = MODE_SEND;
					held_n = item_s1.payload;
				end
			end
			default: begin
				mode_n = mode_q;
			end
		endcase
		res.burst_flag       = burst_n;
		res.sci_pending_flag = pending_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
			mode_q      <= MODE_IDLE;
			held_q      <= '0;
			queued_q    <= '0;
			burst_q     <= 1'b0;
			pending_q   <= 1'b0;
		end else begin
			if (req.valid && req.ready) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				rsp_valid_q <= 1'b1;
				mode_q      <= mode_n;
				held_q      <= held_n;
				queued_q    <= queued_n;
				burst_q     <= burst_n;
				pending_q   <= pending_n;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1 <= req.item;
		end
		if (adv) begin
			rsp_q <= res;
		end
	end

endmodule

// ----- src/ahc_checker.sv -----
// Port-level checks for the ACPI host command handler, attached by bind.
// Depends on ahc_pkg for the result struct.
module ahc_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input ahc_pkg::ahc_rsp_t rsp_item
);
	import ahc_pkg::*;

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
		else $error("result changed while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp_item.read_req && rsp_item.write_req))
		else $error("read and write requested together");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_item.out_valid |-> rsp_item.sci_pulse)
		else $error("output byte without SCI pulse");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_item.sci_accepted |-> rsp_item.sci_pulse && rsp_item.sci_pending_flag)
		else $error("queued event without pulse or pending bit");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_item.out_valid |-> rsp_item.out_byte == 8'h00)
		else $error("output byte set without output valid");

endmodule

bind acpi_ec_host_command_handler ahc_checker u_ahc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_item  (rsp.item)
);
